### rtl/core/tfmi_pkg.sv
`timescale 1ns / 1ps

package tfmi_pkg;

    // Fixed widths of the item fields and the grid store.
    localparam int IDX_W      = 18;
    localparam int DATA_W     = 32;
    localparam int CELL_W     = 10;
    localparam int FRAC_W     = 24;
    localparam int WEIGHT_W   = FRAC_W + 1;
    localparam int NUM_CFG    = 7;
    localparam int CFG_ADDR_W = 5;
    localparam int CELLS_DEFAULT = 63;

    // Operation codes of a request.
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z   = 3'd2;
    localparam logic [2:0] REG_INV_STEP_X = 3'd3;
    localparam logic [2:0] REG_INV_STEP_Y = 3'd4;
    localparam logic [2:0] REG_INV_STEP_Z = 3'd5;
    localparam logic [2:0] REG_OUTSIDE    = 3'd6;

    // Register reset values.
    localparam logic [DATA_W-1:0] RST_ORIGIN_X  = -32'sd889192;
    localparam logic [DATA_W-1:0] RST_ORIGIN_Y  = -32'sd838861;
    localparam logic [DATA_W-1:0] RST_ORIGIN_Z  = -32'sd6710886;
    localparam logic [DATA_W-1:0] RST_INV_STEP  = 32'd131072000;
    localparam logic [DATA_W-1:0] RST_OUTSIDE   = -32'sd1677721600;

    typedef struct packed {
        logic                     operation;
        logic [IDX_W-1:0]         point_index;
        logic signed [DATA_W-1:0] sample_x;
        logic signed [DATA_W-1:0] sample_y;
        logic signed [DATA_W-1:0] sample_z;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] field_x;
        logic signed [DATA_W-1:0] field_y;
        logic signed [DATA_W-1:0] field_z;
        logic                     outside;
    } rsp_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] origin_x;
        logic signed [DATA_W-1:0] origin_y;
        logic signed [DATA_W-1:0] origin_z;
        logic [DATA_W-1:0]        inv_step_x;
        logic [DATA_W-1:0]        inv_step_y;
        logic [DATA_W-1:0]        inv_step_z;
        logic signed [DATA_W-1:0] outside_value;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_STORE   = 2'd0,
        CMD_QUERY   = 2'd1,
        CMD_OUTSIDE = 2'd2
    } cmd_kind_t;

    // Command passed from the front end to the back end.
    typedef struct packed {
        cmd_kind_t                kind;
        logic [IDX_W-1:0]         addr;
        logic [DATA_W-1:0]        sample_x;
        logic [DATA_W-1:0]        sample_y;
        logic [DATA_W-1:0]        sample_z;
        logic [WEIGHT_W-1:0]      frac_x;
        logic [WEIGHT_W-1:0]      frac_y;
        logic [WEIGHT_W-1:0]      frac_z;
    } cmd_t;

endpackage

### rtl/core/tfmi_fifo.sv
`timescale 1ns / 1ps

module tfmi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/core/tfmi_front.sv
`timescale 1ns / 1ps

module tfmi_front #(
    parameter int CELLS_X = tfmi_pkg::CELLS_DEFAULT,
    parameter int CELLS_Y = tfmi_pkg::CELLS_DEFAULT,
    parameter int CELLS_Z = tfmi_pkg::CELLS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tfmi_pkg::req_t  request,
    output logic            full,
    input  tfmi_pkg::cfg_t  cfg,
    output logic            cmd_valid,
    output tfmi_pkg::cmd_t  cmd,
    input  logic            cmd_full
);

    import tfmi_pkg::*;

    localparam int STRIDE_Y = CELLS_Z + 1;
    localparam int STRIDE_X = (CELLS_Y + 1) * STRIDE_Y;
    localparam int PROD_W   = 48;
    localparam int SUM_W    = PROD_W + 1;
    localparam int CELLS_A [3] = '{CELLS_X, CELLS_Y, CELLS_Z};

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MUL  = 5'b00010,
        F_MAP  = 5'b00100,
        F_IDX  = 5'b01000,
        F_PUSH = 5'b10000
    } fstate_t;

    fstate_t                  state_reg, state_next;
    logic signed [DATA_W:0]   diff_reg [3];
    logic [PROD_W-1:0]        prod_hi_reg [3];
    logic [PROD_W-1:0]        prod_lo_reg [3];
    logic [CELL_W-1:0]        cell_reg [3];
    logic [WEIGHT_W-1:0]      frac_reg [3];
    cmd_t                     cmd_reg;

    logic signed [DATA_W-1:0] pos_a [3];
    logic signed [DATA_W-1:0] origin_a [3];
    logic [DATA_W-1:0]        inv_a [3];
    logic [SUM_W-1:0]         scaled [3];
    logic [SUM_W-1:0]         limit [3];
    logic                     off_grid [3];
    logic [31:0]              base_full;

    assign pos_a[0]    = request.pos_x;
    assign pos_a[1]    = request.pos_y;
    assign pos_a[2]    = request.pos_z;
    assign origin_a[0] = cfg.origin_x;
    assign origin_a[1] = cfg.origin_y;
    assign origin_a[2] = cfg.origin_z;
    assign inv_a[0]    = cfg.inv_step_x;
    assign inv_a[1]    = cfg.inv_step_y;
    assign inv_a[2]    = cfg.inv_step_z;

    assign full      = (state_reg != F_IDLE);
    assign cmd_valid = (state_reg == F_PUSH);
    assign cmd       = cmd_reg;

    // Cell coordinate per axis and its range check.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            scaled[a]   = SUM_W'(prod_hi_reg[a]) + SUM_W'(prod_lo_reg[a][PROD_W-1:16]);
            limit[a]    = SUM_W'(CELLS_A[a]) << FRAC_W;
            off_grid[a] = diff_reg[a][DATA_W] || (scaled[a] > limit[a]);
        end
    end

    // Linear index of the lower corner, wrapped to the store size.
    assign base_full = 32'(cell_reg[0]) * 32'(STRIDE_X)
                     + 32'(cell_reg[1]) * 32'(STRIDE_Y)
                     + 32'(cell_reg[2]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    state_next = (request.operation == OP_STORE) ? F_PUSH : F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_MAP;
            end
            F_MAP:
            begin
                state_next = (off_grid[0] || off_grid[1] || off_grid[2]) ? F_PUSH : F_IDX;
            end
            F_IDX:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!cmd_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath: offset, scaling products, cell and fraction, command build.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
            begin
                cmd_reg.addr     <= request.point_index;
                cmd_reg.sample_x <= request.sample_x;
                cmd_reg.sample_y <= request.sample_y;
                cmd_reg.sample_z <= request.sample_z;
                cmd_reg.kind     <= CMD_STORE;
                for (int a = 0; a < 3; a++)
                begin
                    diff_reg[a] <= (DATA_W+1)'(pos_a[a]) - (DATA_W+1)'(origin_a[a]);
                end
            end
            F_MUL:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    prod_hi_reg[a] <= PROD_W'(diff_reg[a][31:16]) * PROD_W'(inv_a[a]);
                    prod_lo_reg[a] <= PROD_W'(diff_reg[a][15:0]) * PROD_W'(inv_a[a]);
                end
            end
            F_MAP:
            begin
                cmd_reg.kind <= (off_grid[0] || off_grid[1] || off_grid[2]) ?
                                CMD_OUTSIDE : CMD_QUERY;
                for (int a = 0; a < 3; a++)
                begin
                    if (scaled[a] == limit[a])
                    begin
                        cell_reg[a] <= CELL_W'(CELLS_A[a] - 1);
                        frac_reg[a] <= WEIGHT_W'(1) << FRAC_W;
                    end
                    else
                    begin
                        cell_reg[a] <= scaled[a][FRAC_W +: CELL_W];
                        frac_reg[a] <= {1'b0, scaled[a][FRAC_W-1:0]};
                    end
                end
            end
            F_IDX:
            begin
                cmd_reg.addr   <= base_full[IDX_W-1:0];
                cmd_reg.frac_x <= frac_reg[0];
                cmd_reg.frac_y <= frac_reg[1];
                cmd_reg.frac_z <= frac_reg[2];
            end
            F_PUSH:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/core/tfmi_back.sv
`timescale 1ns / 1ps

module tfmi_back #(
    parameter int CELLS_Y = tfmi_pkg::CELLS_DEFAULT,
    parameter int CELLS_Z = tfmi_pkg::CELLS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tfmi_pkg::cmd_t                     cmd,
    input  logic                               cmd_empty,
    output logic                               cmd_pop,
    input  logic signed [tfmi_pkg::DATA_W-1:0] outside_value,
    output logic                               res_push,
    output tfmi_pkg::rsp_t                     res,
    input  logic                               res_full
);

    import tfmi_pkg::*;

    localparam int STRIDE_Y = CELLS_Z + 1;
    localparam int STRIDE_X = (CELLS_Y + 1) * STRIDE_Y;
    localparam logic [IDX_W-1:0] OFF_X = IDX_W'(STRIDE_X);
    localparam logic [IDX_W-1:0] OFF_Y = IDX_W'(STRIDE_Y);
    localparam int DEPTH    = 1 << IDX_W;
    localparam int MUL_W    = DATA_W + WEIGHT_W + 1;
    localparam int ACC_W    = MUL_W + 1;
    localparam int LINE_N   = 8;
    localparam int LAST_STEP = LINE_N - 2;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_READ = 5'b00010,
        B_MUL  = 5'b00100,
        B_ADD  = 5'b01000,
        B_OUT  = 5'b10000
    } bstate_t;

    typedef logic [2:0][DATA_W-1:0] vec_t;

    logic [3*DATA_W-1:0]       mem [DEPTH];
    logic [3*DATA_W-1:0]       rd_data_reg;

    bstate_t                   state_reg, state_next;
    logic [IDX_W-1:0]          base_reg;
    logic [WEIGHT_W-1:0]       fx_reg, fy_reg, fz_reg;
    logic [3:0]                cnt_reg;
    logic [2:0]                step_reg;
    vec_t                      line_reg [LINE_N];
    logic signed [MUL_W-1:0]   prod_a_reg [3];
    logic signed [MUL_W-1:0]   prod_b_reg [3];
    rsp_t                      res_reg;

    logic [IDX_W-1:0]          rd_addr;
    logic                      mem_we;
    logic [WEIGHT_W-1:0]       wb;
    logic [WEIGHT_W-1:0]       wa;
    logic signed [ACC_W-1:0]   acc [3];
    vec_t                      blend;

    assign res     = res_reg;
    assign res_push = (state_reg == B_OUT);
    assign cmd_pop = (state_reg == B_IDLE) && !cmd_empty;
    assign mem_we  = cmd_pop && (cmd.kind == CMD_STORE);

    // Corner address: count bit 0 steps x, bit 1 steps y, bit 2 steps z.
    assign rd_addr = base_reg + (cnt_reg[0] ? OFF_X : '0) + (cnt_reg[1] ? OFF_Y : '0)
                   + IDX_W'(cnt_reg[2]);

    // Grid store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cmd.addr] <= {cmd.sample_z, cmd.sample_y, cmd.sample_x};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Blend weights: fx for the four x blends, fy for two, fz for the last.
    always_comb
    begin
        if (step_reg < 3'd4)
        begin
            wb = fx_reg;
        end
        else if (step_reg < 3'd6)
        begin
            wb = fy_reg;
        end
        else
        begin
            wb = fz_reg;
        end
        wa = (WEIGHT_W'(1) << FRAC_W) - wb;
    end

    // Sum of the weighted pair, rounded half up, floor shift.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc[c]   = ACC_W'(prod_a_reg[c]) + ACC_W'(prod_b_reg[c])
                     + (ACC_W'(1) << (FRAC_W - 1));
            blend[c] = acc[c][FRAC_W +: DATA_W];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_pop && (cmd.kind == CMD_QUERY))
                begin
                    state_next = B_READ;
                end
                else if (cmd_pop && (cmd.kind == CMD_OUTSIDE))
                begin
                    state_next = B_OUT;
                end
            end
            B_READ:
            begin
                if (cnt_reg == 4'd8)
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                state_next = B_ADD;
            end
            B_ADD:
            begin
                state_next = (step_reg == 3'(LAST_STEP)) ? B_OUT : B_MUL;
            end
            B_OUT:
            begin
                if (!res_full)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath: corner gathering, blend sequence, result register.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                base_reg <= cmd.addr;
                fx_reg   <= cmd.frac_x;
                fy_reg   <= cmd.frac_y;
                fz_reg   <= cmd.frac_z;
                cnt_reg  <= '0;
                step_reg <= '0;
                res_reg  <= '{field_x: outside_value, field_y: '0, field_z: '0,
                              outside: 1'b1};
            end
            B_READ:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg != '0)
                begin
                    for (int i = 0; i < LINE_N - 1; i++)
                    begin
                        line_reg[i] <= line_reg[i+1];
                    end
                    line_reg[LINE_N-1] <= rd_data_reg;
                end
            end
            B_MUL:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_a_reg[c] <= MUL_W'($signed(line_reg[0][c]))
                                   * $signed({1'b0, wa});
                    prod_b_reg[c] <= MUL_W'($signed(line_reg[1][c]))
                                   * $signed({1'b0, wb});
                end
            end
            B_ADD:
            begin
                // Drop the consumed pair and queue the blend behind the rest.
                for (int i = 0; i < LINE_N; i++)
                begin
                    if (i == (LAST_STEP - int'(step_reg)))
                    begin
                        line_reg[i] <= blend;
                    end
                    else if (i < LINE_N - 2)
                    begin
                        line_reg[i] <= line_reg[i+2];
                    end
                end
                step_reg <= step_reg + 1'b1;
                res_reg  <= '{field_x: blend[0], field_y: blend[1], field_z: blend[2],
                              outside: 1'b0};
            end
            B_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/core/trilinear_field_map_interpolator.sv
`timescale 1ns / 1ps

// Trilinear field map interpolator.
// Requests enter on push/full and are accepted when push is high and full is
// low. A store request writes one grid point's three components; a query
// request returns one result on the result queue (empty/pop), which holds the
// interpolated field or, off the grid, the outside value with outside set.
// The front end passes a store straight on and a query through its multiply,
// map and, on the grid, index steps. The back end writes a store as it pops
// it; a query reads the eight corners through the single read port, then runs
// 7 blends, each a multiply and an add step; an off-grid query goes straight
// out. A two-entry command queue separates the halves, so the front end keeps
// accepting while the back end is busy. When the receiver stalls, results
// wait in a two-entry queue, then the back end holds, then the command queue
// fills and full rises. Reset clears the control state and loads the register
// defaults; the grid store is not cleared and must be written before it is
// queried. The user must write the registers on the APB-style port only
// while the block is idle; the block itself does not enforce this.

module trilinear_field_map_interpolator #(
    parameter int CELLS_X = tfmi_pkg::CELLS_DEFAULT,
    parameter int CELLS_Y = tfmi_pkg::CELLS_DEFAULT,
    parameter int CELLS_Z = tfmi_pkg::CELLS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  tfmi_pkg::req_t                       request,
    output logic                                 full,
    input  logic                                 pop,
    output tfmi_pkg::rsp_t                       result,
    output logic                                 empty,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tfmi_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [tfmi_pkg::DATA_W-1:0]          pwdata,
    output logic [tfmi_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    import tfmi_pkg::*;

    cfg_t           cfg_reg;
    logic [2:0]     reg_sel;
    logic           cfg_we;

    logic           cmd_push;
    cmd_t           cmd_in;
    logic           cmd_full;
    logic [$bits(cmd_t)-1:0] cmd_out_bits;
    cmd_t           cmd_out;
    logic           cmd_empty;
    logic           cmd_pop;

    logic           res_push;
    rsp_t           res_in;
    logic           res_full;
    logic [$bits(rsp_t)-1:0] res_out_bits;

    assign pready  = 1'b1;
    assign reg_sel = paddr[CFG_ADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{origin_x: RST_ORIGIN_X, origin_y: RST_ORIGIN_Y,
                         origin_z: RST_ORIGIN_Z, inv_step_x: RST_INV_STEP,
                         inv_step_y: RST_INV_STEP, inv_step_z: RST_INV_STEP,
                         outside_value: RST_OUTSIDE};
        end
        else if (cfg_we)
        begin
            unique case (reg_sel)
                REG_ORIGIN_X:   cfg_reg.origin_x      <= pwdata;
                REG_ORIGIN_Y:   cfg_reg.origin_y      <= pwdata;
                REG_ORIGIN_Z:   cfg_reg.origin_z      <= pwdata;
                REG_INV_STEP_X: cfg_reg.inv_step_x    <= pwdata;
                REG_INV_STEP_Y: cfg_reg.inv_step_y    <= pwdata;
                REG_INV_STEP_Z: cfg_reg.inv_step_z    <= pwdata;
                REG_OUTSIDE:    cfg_reg.outside_value <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_sel)
            REG_ORIGIN_X:   prdata = cfg_reg.origin_x;
            REG_ORIGIN_Y:   prdata = cfg_reg.origin_y;
            REG_ORIGIN_Z:   prdata = cfg_reg.origin_z;
            REG_INV_STEP_X: prdata = cfg_reg.inv_step_x;
            REG_INV_STEP_Y: prdata = cfg_reg.inv_step_y;
            REG_INV_STEP_Z: prdata = cfg_reg.inv_step_z;
            REG_OUTSIDE:    prdata = cfg_reg.outside_value;
            default:        prdata = '0;
        endcase
    end

    // Front end: request acceptance and cell mapping.
    tfmi_front #(
        .CELLS_X (CELLS_X),
        .CELLS_Y (CELLS_Y),
        .CELLS_Z (CELLS_Z)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .full      (full),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_push),
        .cmd       (cmd_in),
        .cmd_full  (cmd_full)
    );

    // Command queue between the two halves.
    tfmi_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_out_bits),
        .empty (cmd_empty)
    );

    assign cmd_out = cmd_t'(cmd_out_bits);

    // Back end: grid store and blending.
    tfmi_back #(
        .CELLS_Y (CELLS_Y),
        .CELLS_Z (CELLS_Z)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_out),
        .cmd_empty     (cmd_empty),
        .cmd_pop       (cmd_pop),
        .outside_value (cfg_reg.outside_value),
        .res_push      (res_push),
        .res           (res_in),
        .res_full      (res_full)
    );

    // Result queue toward the receiver.
    tfmi_fifo #(
        .WIDTH ($bits(rsp_t)),
        .DEPTH (2)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out_bits),
        .empty (empty)
    );

    assign result = rsp_t'(res_out_bits);

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tfmi_pkg::*;

    localparam int GRID_CELLS  = 63;
    localparam int ROW_STRIDE  = GRID_CELLS + 1;
    localparam int PLANE_STRIDE = (GRID_CELLS + 1) * (GRID_CELLS + 1);
    localparam int STORE_DEPTH = 262144;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 500;
    localparam logic [DATA_W-1:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S_MIN = 32'h8000_0000;

    // Scoreboard: a copy of the grid store and the registers, and the
    // expected query results still waiting to come out of the block.
    class field_scoreboard;
        logic [DATA_W-1:0] grid_x [];
        logic [DATA_W-1:0] grid_y [];
        logic [DATA_W-1:0] grid_z [];
        bit                written [];
        cfg_t              regs;
        rsp_t              field_q [$];
        int                errors;

        function new();
            grid_x  = new[STORE_DEPTH];
            grid_y  = new[STORE_DEPTH];
            grid_z  = new[STORE_DEPTH];
            written = new[STORE_DEPTH];
            errors  = 0;
            regs.origin_x      = RST_ORIGIN_X;
            regs.origin_y      = RST_ORIGIN_Y;
            regs.origin_z      = RST_ORIGIN_Z;
            regs.inv_step_x    = RST_INV_STEP;
            regs.inv_step_y    = RST_INV_STEP;
            regs.inv_step_z    = RST_INV_STEP;
            regs.outside_value = RST_OUTSIDE;
        endfunction

        function void report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] v);
            case (idx)
                REG_ORIGIN_X:   regs.origin_x = v;
                REG_ORIGIN_Y:   regs.origin_y = v;
                REG_ORIGIN_Z:   regs.origin_z = v;
                REG_INV_STEP_X: regs.inv_step_x = v;
                REG_INV_STEP_Y: regs.inv_step_y = v;
                REG_INV_STEP_Z: regs.inv_step_z = v;
                default:        regs.outside_value = v;
            endcase
        endfunction

        // Scale one coordinate into a cell and a Q1.24 fraction.
        function bit map_axis(logic signed [DATA_W-1:0] pos, logic signed [DATA_W-1:0] origin,
                              logic [DATA_W-1:0] inv, output int cell_idx, output int frac);
            longint   d;
            bit [63:0] ud, p, limit;
            d = longint'(pos) - longint'(origin);
            cell_idx = 0;
            frac = 0;
            if (d < 0)
                return 0;
            ud = d;
            p = (ud >> 16) * inv + (((ud & 64'hFFFF) * inv) >> 16);
            limit = 64'(GRID_CELLS) << FRAC_W;
            if (p > limit)
                return 0;
            if (p == limit)
            begin
                cell_idx = GRID_CELLS - 1;
                frac = 1 << FRAC_W;
            end
            else
            begin
                cell_idx = int'(p >> FRAC_W);
                frac = int'(p & 64'hFF_FFFF);
            end
            return 1;
        endfunction

        // Work out the eight corner indexes; returns 0 off the grid.
        function bit locate(req_t r, output int idx [8], output int fx, output int fy,
                            output int fz);
            int cx, cy, cz;
            bit in_grid;
            in_grid = map_axis(r.pos_x, regs.origin_x, regs.inv_step_x, cx, fx)
                   && map_axis(r.pos_y, regs.origin_y, regs.inv_step_y, cy, fy)
                   && map_axis(r.pos_z, regs.origin_z, regs.inv_step_z, cz, fz);
            for (int i = 0; i < 8; i++)
                idx[i] = ((cx + ((i >> 2) & 1)) * PLANE_STRIDE + (cy + ((i >> 1) & 1)) * ROW_STRIDE
                         + (cz + (i & 1))) % STORE_DEPTH;
            return in_grid;
        endfunction

        function longint blend(longint a, longint b, int f);
            longint s;
            s = a * longint'((1 << FRAC_W) - f) + b * longint'(f) + longint'(1 << (FRAC_W - 1));
            return s >>> FRAC_W;
        endfunction

        function logic [DATA_W-1:0] interpolate(ref logic [DATA_W-1:0] g [], input int idx [8],
                                                input int fx, input int fy, input int fz);
            longint c00, c10, c01, c11;
            c00 = blend(longint'($signed(g[idx[0]])), longint'($signed(g[idx[4]])), fx);
            c10 = blend(longint'($signed(g[idx[2]])), longint'($signed(g[idx[6]])), fx);
            c01 = blend(longint'($signed(g[idx[1]])), longint'($signed(g[idx[5]])), fx);
            c11 = blend(longint'($signed(g[idx[3]])), longint'($signed(g[idx[7]])), fx);
            return DATA_W'(blend(blend(c00, c10, fy), blend(c01, c11, fy), fz));
        endfunction

        // An accepted request: update the store or predict the field.
        function void note_request(req_t r);
            int   idx [8];
            int   fx, fy, fz;
            rsp_t e;
            if (r.operation == OP_STORE)
            begin
                grid_x[r.point_index] = r.sample_x;
                grid_y[r.point_index] = r.sample_y;
                grid_z[r.point_index] = r.sample_z;
                return;
            end
            if (!locate(r, idx, fx, fy, fz))
            begin
                e.field_x = regs.outside_value;
                e.field_y = '0;
                e.field_z = '0;
                e.outside = 1'b1;
            end
            else
            begin
                e.field_x = interpolate(grid_x, idx, fx, fy, fz);
                e.field_y = interpolate(grid_y, idx, fx, fy, fz);
                e.field_z = interpolate(grid_z, idx, fx, fy, fz);
                e.outside = 1'b0;
            end
            field_q.push_back(e);
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            if (field_q.size() == 0)
            begin
                report("result with no query waiting");
                return;
            end
            e = field_q.pop_front();
            if (got.field_x !== e.field_x)
                report($sformatf("field_x got %h want %h", got.field_x, e.field_x));
            if (got.field_y !== e.field_y)
                report($sformatf("field_y got %h want %h", got.field_y, e.field_y));
            if (got.field_z !== e.field_z)
                report($sformatf("field_z got %h want %h", got.field_z, e.field_z));
            if (got.outside !== e.outside)
                report($sformatf("outside got %b want %b", got.outside, e.outside));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic push;
    req_t request;
    logic full;
    logic pop;
    rsp_t result;
    logic empty;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    field_scoreboard sb = new();
    int  cycles = 0;
    int  burst_left = 0;
    bit  hold_start = 0;
    int  hold_left = 0;

    trilinear_field_map_interpolator DUT (
        .clk(clk), .rst_n(rst_n),
        .push(push), .request(request), .full(full),
        .pop(pop), .result(result), .empty(empty),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: checks each popped result and stalls on a rotating pattern,
    // with one long hold-off on request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                sb.check_result(result);
            if (hold_start)
            begin
                hold_start = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                case ((cycles / 97) % 3)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(0, 1) == 1);
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one request and wait until it is accepted; bursts and gaps.
    task automatic send(req_t r);
        push <= 1'b1;
        request <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_request(r);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    endtask

    task automatic store_point(int idx, logic [DATA_W-1:0] vx, logic [DATA_W-1:0] vy,
                               logic [DATA_W-1:0] vz);
        req_t r;
        r = '0;
        r.operation = OP_STORE;
        r.point_index = IDX_W'(idx);
        r.sample_x = vx;
        r.sample_y = vy;
        r.sample_z = vz;
        r.pos_x = $urandom;
        r.pos_y = $urandom;
        r.pos_z = $urandom;
        sb.written[idx] = 1'b1;
        send(r);
    endtask

    function automatic logic [DATA_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Query a position, first filling any corner of its cell never written.
    task automatic query_at(logic [DATA_W-1:0] px, logic [DATA_W-1:0] py, logic [DATA_W-1:0] pz);
        req_t r;
        int   idx [8];
        int   fx, fy, fz;
        r = '0;
        r.operation = OP_QUERY;
        r.point_index = IDX_W'($urandom);
        r.sample_x = $urandom;
        r.sample_y = $urandom;
        r.sample_z = $urandom;
        r.pos_x = px;
        r.pos_y = py;
        r.pos_z = pz;
        if (sb.locate(r, idx, fx, fy, fz))
            foreach (idx[i])
                if (!sb.written[idx[i]])
                    store_point(idx[i], rand_sample(), rand_sample(), rand_sample());
        send(r);
    endtask

    // Position whose scaled coordinate lands near or inside the grid.
    function automatic logic [DATA_W-1:0] aim(logic [DATA_W-1:0] origin, logic [DATA_W-1:0] inv);
        longint u, dd, p;
        if ($urandom_range(0, 15) == 0)
            u = longint'(GRID_CELLS) << FRAC_W;
        else
            u = (longint'($urandom_range(0, GRID_CELLS)) << FRAC_W)
                + longint'($urandom_range(0, (1 << FRAC_W) - 1));
        if (inv == 0)
            dd = $urandom_range(0, 1000);
        else
            dd = (u << 16) / longint'(inv);
        if ($urandom_range(0, 9) == 0)
            dd = dd - $urandom_range(1, 3);
        p = longint'($signed(origin)) + dd;
        if (p > 64'sh7FFF_FFFF)
            p = 64'sh7FFF_FFFF;
        return DATA_W'(p);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(idx) << 2;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // Let every query drain, plus the tail of any store still in flight.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (sb.field_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(logic [DATA_W-1:0] ox, logic [DATA_W-1:0] oy,
                               logic [DATA_W-1:0] oz, logic [DATA_W-1:0] ix,
                               logic [DATA_W-1:0] iy, logic [DATA_W-1:0] iz,
                               logic [DATA_W-1:0] ov);
        wait_idle();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_INV_STEP_X, ix);
        write_reg(REG_INV_STEP_Y, iy);
        write_reg(REG_INV_STEP_Z, iz);
        write_reg(REG_OUTSIDE, ov);
    endtask

    // Mixed random traffic under the current register settings.
    task automatic random_phase(int count, bit with_hold);
        int k;
        for (int n = 0; n < count; n++)
        begin
            if (with_hold && n == count / 3)
                hold_start = 1;
            k = $urandom_range(0, 19);
            if (k < 14)
                query_at(aim(sb.regs.origin_x, sb.regs.inv_step_x),
                         aim(sb.regs.origin_y, sb.regs.inv_step_y),
                         aim(sb.regs.origin_z, sb.regs.inv_step_z));
            else if (k < 17)
                query_at($urandom, $urandom, $urandom);
            else
                store_point($urandom_range(0, STORE_DEPTH - 1), rand_sample(),
                            rand_sample(), rand_sample());
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        push <= 1'b0;
        request <= '0;
        pop <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, extreme indexes and samples, below the
        // origin, at the origin and at extreme positions.
        store_point(0, S_MAX, S_MIN, 32'h0);
        store_point(STORE_DEPTH - 1, S_MIN, S_MAX, 32'hFFFF_FFFF);
        query_at(sb.regs.origin_x - 1, sb.regs.origin_y, sb.regs.origin_z);
        query_at(sb.regs.origin_x, sb.regs.origin_y, sb.regs.origin_z);
        query_at(S_MIN, S_MIN, S_MIN);
        query_at(S_MAX, S_MAX, S_MAX);
        query_at(aim(sb.regs.origin_x, sb.regs.inv_step_x),
                 aim(sb.regs.origin_y, sb.regs.inv_step_y),
                 aim(sb.regs.origin_z, sb.regs.inv_step_z));

        // Directed: one cell per metre from the lowest origin, so the upper
        // edge is hit exactly and just past it.
        load_config(S_MIN, S_MIN, S_MIN, 32'h1_0000, 32'h1_0000, 32'h1_0000, S_MAX);
        query_at(S_MIN + (GRID_CELLS << FRAC_W), S_MIN + (GRID_CELLS << FRAC_W),
                 S_MIN + (GRID_CELLS << FRAC_W));
        query_at(S_MIN + (GRID_CELLS << FRAC_W) + 1, S_MIN, S_MIN);
        query_at(S_MIN, S_MIN, S_MIN + (GRID_CELLS << FRAC_W) + 1);
        query_at(S_MIN + (1 << (FRAC_W - 1)), S_MIN + (1 << (FRAC_W - 1)),
                 S_MIN + (1 << (FRAC_W - 1)));
        query_at(S_MIN + (5 << FRAC_W), S_MIN + (62 << FRAC_W), S_MIN + 1);

        // Directed: zero step reads corner zero; highest origin.
        load_config(S_MAX, 32'h0, S_MIN, 32'h0, 32'h0, 32'h0, S_MIN);
        query_at(S_MAX, 32'h1234_5678, S_MAX);
        query_at(S_MAX - 1, 32'h0, S_MIN);
        query_at(S_MAX, 32'hFFFF_FFFF, 32'h0);

        // Random phases through several settings. Most queries land in a
        // fresh cell and first fill its corners, so each step sends several
        // requests.
        load_config(RST_ORIGIN_X, RST_ORIGIN_Y, RST_ORIGIN_Z, RST_INV_STEP, RST_INV_STEP,
                    RST_INV_STEP, RST_OUTSIDE);
        random_phase(75, 1'b1);
        load_config($urandom, $urandom, $urandom, $urandom_range(1 << 16, 1 << 26),
                    $urandom_range(1 << 16, 1 << 26), $urandom_range(1 << 16, 1 << 26), $urandom);
        random_phase(65, 1'b0);
        load_config(S_MIN, 32'h0, S_MAX - 32'h0100_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'h0);
        random_phase(60, 1'b0);
        load_config(S_MIN, S_MIN, S_MIN, 32'h1, 32'h1, 32'h1, $urandom);
        random_phase(40, 1'b0);
        load_config(32'hFF00_0000, 32'h0000_1000, 32'hF000_0000, 32'h8000_0000,
                    32'h0040_0000, 32'h0123_4567, $urandom);
        random_phase(45, 1'b0);

        wait_idle();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
